### hw/rtl/lbp_pkg.sv
// shared types and constants for the 3x3 local binary pattern block
package lbp_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int IDX_W      = 2;
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  localparam logic [SIZE_W-1:0] SIZE_MIN       = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] WIDTH_MAX      = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX     = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] WIDTH_RESET    = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET   = SIZE_W'(480);

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [COL_W-1:0] col_t;

  // position flags of one accepted pixel
  typedef struct packed {
    logic produce;
    logic last;
  } scan_info_t;

  // one result entry
  typedef struct packed {
    logic   last;
    pixel_t code;
  } result_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] x;
    x = v;
    if (x < SIZE_MIN) x = SIZE_MIN;
    if (x > hi) x = hi;
    return x;
  endfunction

endpackage

### hw/rtl/lbp_line_ram.sv
// one line store: synchronous ram, one write port, one registered read port
module lbp_line_ram
  import lbp_pkg::*;
(
  input  logic   clk,
  input  logic   rd_en,
  input  col_t   rd_addr,
  output pixel_t rd_data,
  input  logic   wr_en,
  input  col_t   wr_addr,
  input  pixel_t wr_data
);

  pixel_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/lbp_scan.sv
// frame size registers and raster position counters
module lbp_scan
  import lbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              advance,
  output col_t              col,
  output scan_info_t        info,
  output logic [SIZE_W-1:0] frame_width
);

  logic [SIZE_W-1:0] frame_height;
  logic [ROW_W-1:0]  row;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;
  logic              known_reg;

  assign col_inc   = {1'b0, col} + SIZE_W'(1);
  assign row_inc   = {1'b0, row} + SIZE_W'(1);
  assign known_reg = (cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT);

  assign info.produce = (row >= ROW_W'(2)) && (col >= COL_W'(2));
  assign info.last    = (row_inc == frame_height) && (col_inc == frame_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
    end else if (cfg_write && known_reg) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= clamp_size(cfg_data, WIDTH_MAX);
      end else begin
        frame_height <= clamp_size(cfg_data, HEIGHT_MAX);
      end
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (col_inc >= frame_width) begin
        col <= '0;
        if (row_inc >= frame_height) begin
          row <= '0;
        end else begin
          row <= row_inc[ROW_W-1:0];
        end
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

endmodule

### hw/rtl/lbp_window.sv
// write-back stage: line store update, window shift and the eight compares
module lbp_window
  import lbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  pixel_t     pixel,
  input  col_t       col,
  input  scan_info_t info,
  input  pixel_t     top_rd,
  input  pixel_t     mid_rd,
  output logic       wr_en,
  output col_t       wr_addr,
  output pixel_t     wr_pixel,
  output logic       push,
  output result_t    result
);

  logic       busy;
  scan_info_t info_q;
  pixel_t     pix_q;
  col_t       col_q;

  // window columns 1 and 2; column 0 is only ever read after the shift
  pixel_t w01, w02, w11, w12, w21, w22;
  pixel_t centre;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      info_q <= info;
      pix_q  <= pixel;
      col_q  <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      w01 <= w02;
      w02 <= top_rd;
      w11 <= w12;
      w12 <= mid_rd;
      w21 <= w22;
      w22 <= pix_q;
    end
  end

  assign wr_en    = busy;
  assign wr_addr  = col_q;
  assign wr_pixel = pix_q;

  assign centre = w12;

  always_comb begin
    result.last    = info_q.last;
    result.code[0] = centre <= w01;
    result.code[1] = centre <= w02;
    result.code[2] = centre <= top_rd;
    result.code[3] = centre <= w11;
    result.code[4] = centre <= mid_rd;
    result.code[5] = centre <= w21;
    result.code[6] = centre <= w22;
    result.code[7] = centre <= pix_q;
  end

  assign push = busy && info_q.produce;

endmodule

### hw/rtl/lbp_out_fifo.sv
// three-entry result queue that decouples the output side
module lbp_out_fifo
  import lbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  input  logic                  pop,
  output logic                  not_empty,
  output result_t               head,
  output logic [FIFO_CNT_W-1:0] count
);

  result_t                 slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic                    do_pop;

  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
      if (push && !do_pop) begin
        count <= count + FIFO_CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/lbp_3x3_pixel_stream_top.sv
// top level of the 3x3 local binary pattern block on a gray pixel stream
// usage:
//   s_axis carries 8-bit gray pixels in raster order, one request per pixel
//   m_axis returns one 8-bit pattern code per interior pixel, raster order;
//   tlast marks the code of the last interior pixel of the frame
//   cfg writes frame_width (index 0) or frame_height (index 1), clamped to
//   3..4096; such a write restarts the frame, other indexes are ignored
// path: a pixel is accepted, its two line-store reads land next cycle,
//   the code is formed in that cycle and enters the output queue; the code
//   is visible on m_axis once the output queue has registered it
// throughput: one pixel per clock unless stalled, set by the single read
//   and single write port of each store (read at accept, write back next cycle)
// reset: sizes return to 640x480, counters to row 0 column 0, queue empties;
//   the line stores are not cleared, their stale entries only feed the first
//   two rows where no code is produced
// stall: a three-entry output queue absorbs the code in flight; s_axis_tready
//   drops only when the queue and the pixel in flight would overfill it
module lbp_3x3_pixel_stream_top
  import lbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // pixel in
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] pixel
  // pattern code out
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] pattern_code
  output logic              m_axis_tlast,   // frame_last
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic                  accept;
  col_t                  col;
  scan_info_t            info;
  logic [SIZE_W-1:0]     frame_width;
  pixel_t                top_rd;
  pixel_t                mid_rd;
  logic                  wr_en;
  col_t                  wr_addr;
  pixel_t                wr_pixel;
  logic                  push;
  result_t               result;
  result_t               head;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  // queue entries plus a code still being formed must leave room for one more
  assign occupancy     = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, push};
  assign s_axis_tready = occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH);

  lbp_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .advance     (accept),
    .col         (col),
    .info        (info),
    .frame_width (frame_width)
  );

  // upper store keeps the row two above, middle store the row just above
  lbp_line_ram u_upper (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (top_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (mid_rd)
  );

  lbp_line_ram u_middle (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (mid_rd),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_pixel)
  );

  lbp_window u_window (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .pixel    (s_axis_tdata),
    .col      (col),
    .info     (info),
    .top_rd   (top_rd),
    .mid_rd   (mid_rd),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_pixel (wr_pixel),
    .push     (push),
    .result   (result)
  );

  lbp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (m_axis_tready),
    .not_empty (m_axis_tvalid),
    .head      (head),
    .count     (fifo_count)
  );

  assign m_axis_tdata = head.code;
  assign m_axis_tlast = head.last;

  // the queue never takes a code while full
  assert property (@(posedge clk) disable iff (rst)
    !(push && fifo_count == FIFO_CNT_W'(FIFO_DEPTH) && !m_axis_tready))
    else $error("result queue overflow");

  // column position stays inside the configured row
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < frame_width)
    else $error("column counter beyond frame width");

  // every accepted pixel is written back into the line stores next cycle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> wr_en && wr_addr == $past(col))
    else $error("line store write-back missing");

  // a read never targets the entry written back in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    accept && wr_en |-> col != wr_addr)
    else $error("line store read and write collide");

endmodule

### sim/tb.sv
// testbench for lbp_3x3_pixel_stream_top: predicted pattern codes against the streamed results
module tb;
  import lbp_pkg::*;

  // register indexes past the two real ones; writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);

  typedef enum logic [1:0] {PIX_FULL, PIX_NARROW, PIX_EXTREME} pixel_mix_e;

  // tracks frame position, line stores and window; queues the codes due out
  class lbp_code_tracker;
    logic [SIZE_W-1:0] frame_w;
    logic [SIZE_W-1:0] frame_h;
    pixel_t upper_row [MAX_WIDTH];
    pixel_t middle_row [MAX_WIDTH];
    pixel_t win [3][3];
    int unsigned col;
    int unsigned row;
    result_t codes_due [$];
    int unsigned errors;
    int unsigned codes_checked;

    function new();
      frame_w = WIDTH_RESET;
      frame_h = HEIGHT_RESET;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      col = 0;
      row = 0;
      errors = 0;
      codes_checked = 0;
    endfunction

    function logic [SIZE_W-1:0] fit_size(logic [SIZE_W-1:0] v, int unsigned top);
      if (v < 3) return SIZE_MIN;
      if (v > top) return SIZE_W'(top);
      return v;
    endfunction

    // any write to a real register restarts the frame
    function void note_write(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: frame_w = fit_size(val, MAX_WIDTH);
        REG_FRAME_HEIGHT: frame_h = fit_size(val, MAX_HEIGHT);
        default: return;
      endcase
      col = 0;
      row = 0;
    endfunction

    function void note_pixel(pixel_t p);
      pixel_t nb [8];
      pixel_t centre;
      result_t want;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = upper_row[col];
      win[1][2] = middle_row[col];
      win[2][2] = p;
      upper_row[col] = middle_row[col];
      middle_row[col] = p;
      if (row >= 2 && col >= 2) begin
        centre = win[1][1];
        nb = '{win[0][0], win[0][1], win[0][2], win[1][0],
               win[1][2], win[2][0], win[2][1], win[2][2]};
        for (int k = 0; k < 8; k++) want.code[k] = (centre <= nb[k]);
        want.last = (row + 1 == frame_h) && (col + 1 == frame_w);
        codes_due.push_back(want);
      end
      col++;
      if (col >= frame_w) begin
        col = 0;
        row++;
        if (row >= frame_h) row = 0;
      end
    endfunction

    function void check_code(pixel_t code, logic last);
      result_t want;
      if (codes_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("code %h last %b arrived with none outstanding", code, last);
        return;
      end
      want = codes_due.pop_front();
      codes_checked++;
      if (code !== want.code || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("result %0d: code exp %h got %h, last exp %b got %b",
                   codes_checked, want.code, code, want.last, last);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  lbp_code_tracker tracker;
  bit          tx_idle;
  bit          rx_idle;
  int          hold_request;
  int unsigned pixels_sent;
  int unsigned cfg_writes;
  int unsigned input_stalls;
  int unsigned random_pixels;
  pixel_t      directed_pix [0:26];

  lbp_3x3_pixel_stream_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #4000000;
    $display("lbp_3x3_pixel_stream_top test failed");
    $finish;
  end

  // result side: check every accepted code, then pick next cycle's ready
  initial begin
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        tracker.check_code(m_axis_tdata, m_axis_tlast);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        // long hold-off so the output queue fills and the input stalls
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.note_write(idx, val);
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one pixel request; valid stays high unless a gap follows
  task automatic send_pixel(pixel_t p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk);
    while (!s_axis_tready) begin
      input_stalls++;
      @(posedge clk);
    end
    tracker.note_pixel(p);
    pixels_sent++;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic pixel_t pick_pixel(pixel_mix_e mix);
    case (mix)
      PIX_NARROW: return pixel_t'($urandom_range(100, 103));
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_run(int n, pixel_mix_e mix);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel(mix));
    s_axis_tvalid <= 1'b0;
  endtask

  // let every expected code arrive, then wait out the border pixel in flight
  task automatic settle();
    while (tracker.codes_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int n;
    int pick;
    pixel_mix_e mix;
    tracker = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 0;
    pixels_sent = 0;
    cfg_writes = 0;
    input_stalls = 0;
    random_pixels = 0;
    // mixed neighbourhood, flat frame (all comparisons equal), bright centre on black
    directed_pix = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h80, 8'hff, 8'h00, 8'hff, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset size 640 wide: a short run inside the first row, no code due
    send_run(40, PIX_FULL);
    settle();

    // widths and heights below three fold to 3x3
    write_reg(REG_FRAME_WIDTH, SIZE_W'(1));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(2));
    for (int i = 0; i < 27; i++) send_pixel(directed_pix[i]);
    s_axis_tvalid <= 1'b0;
    settle();

    // tall frame, three wide; oversize height clamps, long stall on the output
    write_reg(REG_FRAME_WIDTH, SIZE_W'(0));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(8191));
    hold_request = 150;
    send_run(3 * 30, PIX_NARROW);
    settle();

    // oversize width clamps; short runs stay inside the first row
    write_reg(REG_FRAME_WIDTH, SIZE_W'(5000));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(3));
    send_run(20, PIX_FULL);
    settle();
    write_reg(REG_FRAME_WIDTH, SIZE_W'(4096));
    send_run(20, PIX_EXTREME);
    settle();

    // writes past the last register leave the frame position alone
    write_reg(REG_FRAME_WIDTH, SIZE_W'(5));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(4));
    send_run(12, PIX_FULL);
    settle();
    write_reg(REG_SPARE_2, SIZE_W'(3));
    write_reg(REG_SPARE_3, SIZE_W'(8191));
    send_run(28, PIX_FULL);
    settle();

    // restart in the middle of a frame
    write_reg(REG_FRAME_WIDTH, SIZE_W'(6));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(5));
    send_run(20, PIX_FULL);
    settle();
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(5));
    send_run(30, PIX_NARROW);
    settle();

    // random phases, mostly whole frames of small size
    while (random_pixels < 650) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        write_reg(REG_FRAME_WIDTH, SIZE_W'($urandom_range(3, 10)));
        write_reg(REG_FRAME_HEIGHT, SIZE_W'($urandom_range(3, 6)));
      end else if (pick == 6) begin
        write_reg(REG_FRAME_WIDTH, SIZE_W'($urandom_range(0, 12)));
      end else if (pick == 7) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  SIZE_W'($urandom_range(0, 8191)));
      end else if (pick == 8) begin
        write_reg(REG_FRAME_WIDTH, SIZE_W'($urandom_range(0, 8191)));
      end else begin
        write_reg(REG_FRAME_WIDTH, SIZE_W'($urandom_range(3, 8)));
        write_reg(REG_FRAME_HEIGHT, SIZE_W'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 9) < 7)
        n = tracker.frame_w * $urandom_range(3, 6) * $urandom_range(1, 2);
      else
        n = $urandom_range(1, 60);
      if (n > 150) n = 150;
      mix = pixel_mix_e'($urandom_range(0, 2));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (random_pixels == 0) hold_request = 80;
      send_run(n, mix);
      random_pixels += n;
      settle();
    end

    // closing stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_reg(REG_FRAME_WIDTH, SIZE_W'(7));
    write_reg(REG_FRAME_HEIGHT, SIZE_W'(4));
    send_run(2 * 7 * 4, PIX_FULL);
    settle();

    $display("run: %0d pixels, %0d codes checked, %0d register writes",
             pixels_sent, tracker.codes_checked, cfg_writes);
    $display("small and folded frames, clamped sizes up to 4096, input held off %0d cycles",
             input_stalls);
    if (tracker.errors == 0 && tracker.codes_due.size() == 0) begin
      $display("lbp_3x3_pixel_stream_top test passed");
    end else begin
      $display("mismatches %0d, codes still outstanding %0d",
               tracker.errors, tracker.codes_due.size());
      $display("lbp_3x3_pixel_stream_top test failed");
    end
    $finish;
  end

endmodule

### lbp_3x3_pixel_stream_top.f
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_line_ram.sv
hw/rtl/lbp_scan.sv
hw/rtl/lbp_window.sv
hw/rtl/lbp_out_fifo.sv
hw/rtl/lbp_3x3_pixel_stream_top.sv
sim/tb.sv
